@@ src/ptmr_pkg.sv @@
// Shared constants, codes and types for the protection table miss refill core.
`default_nettype none
package ptmr_pkg;

	localparam int ENTRIES    = 16;
	localparam int PAGE_SHIFT = 12;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = IDX_W + 1;

	localparam int CAUSE_W = 6;
	localparam int ADDR_W  = 32;
	localparam int PAGE_W  = 20;
	localparam int WORD_W  = 17;
	localparam int STAT_W  = 2;

	localparam logic [CAUSE_W-1:0] CAUSE_DMISS = 6'h26;
	localparam logic [CAUSE_W-1:0] CAUSE_IMISS = 6'h2c;

	localparam logic [ADDR_W-1:0] ASYNC_BASE    = 32'h2000_0000;
	localparam logic [ADDR_W-1:0] DATA_L1_ADDR  = 32'hFF80_0000;
	localparam logic [ADDR_W-1:0] INSTR_L1_ADDR = 32'hFFA0_0000;

	localparam logic [WORD_W-1:0] DATA_WORD  = 17'h1C01D;
	localparam logic [WORD_W-1:0] INSTR_WORD = 17'h10005;
	localparam logic [WORD_W-1:0] LOCK_BIT   = 17'h00002;
	localparam logic [WORD_W-1:0] CACHE_BIT  = 17'h01000;
	localparam int               VALID_POS  = 0;
	localparam int               LOCK_POS   = 1;

	localparam logic [WORD_W-1:0] DATA_RST_WORD  = DATA_WORD | LOCK_BIT;
	localparam logic [WORD_W-1:0] INSTR_RST_WORD = INSTR_WORD | LOCK_BIT;

	localparam logic [STAT_W-1:0] ST_INSTALLED = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNHANDLED = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_VICTIM = 2'd2;

	localparam logic TBL_DATA  = 1'b0;
	localparam logic TBL_INSTR = 1'b1;

	typedef struct packed {
		logic load;
		logic exec;
	} ptmr_cmd_t;

endpackage
`default_nettype wire

@@ src/protection_table_miss_refill_core.sv @@
// Top level of the protection table miss refill core.
//
// Each transaction carries an exception cause and a fault address and returns one
// result. A data miss (cause 0x26) or instruction miss (cause 0x2c) installs the
// faulting page in the first invalid slot of its 16-entry table, or, when the table
// is full, in the first unlocked slot at or after that table's round-robin pointer.
// Other causes return the unhandled status; a table with every slot locked returns
// the no-victim status and stays unchanged. A transaction first loads the input
// register, then does the slot search and table update over the flopped valid and
// lock bits. The next transaction is accepted in the cycle the result is taken, so
// a new transaction does not enter while the last one is still in its slot search.
`default_nettype none
module protection_table_miss_refill_core
	import ptmr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CAUSE_W-1:0]  opcode,
	input  wire logic [ADDR_W-1:0]   fault_addr,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [STAT_W-1:0]   status,
	output logic                     table_sel,
	output logic      [IDX_W-1:0]    slot,
	output logic      [PAGE_W-1:0]   page_number,
	output logic      [WORD_W-1:0]   entry_word
);

	ptmr_cmd_t cmd;

	ptmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ptmr_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.fault_addr  (fault_addr),
		.status      (status),
		.table_sel   (table_sel),
		.slot        (slot),
		.page_number (page_number),
		.entry_word  (entry_word)
	);

endmodule
`default_nettype wire

@@ src/ptmr_ctrl.sv @@
// Controller state machine: input/output handshakes and datapath sequencing.
`default_nettype none
module ptmr_ctrl
	import ptmr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output ptmr_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       take_in;

	// accept a new transaction when idle or while the finished result leaves
	assign in_stall  = !((state_q == S_IDLE) || ((state_q == S_DONE) && !out_stall));
	assign out_valid = (state_q == S_DONE);
	assign take_in   = in_valid && !in_stall;

	assign cmd.load = take_in;
	assign cmd.exec = (state_q == S_SRCH);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_SRCH;
			end
			S_SRCH: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!out_stall) state_nxt = in_valid ? S_SRCH : S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

@@ src/ptmr_dpath.sv @@
// Datapath: valid/lock flags, victim pointers, slot search and result registers.
`default_nettype none
module ptmr_dpath
	import ptmr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ptmr_cmd_t           cmd,
	input  wire logic [CAUSE_W-1:0]  opcode,
	input  wire logic [ADDR_W-1:0]   fault_addr,
	output logic      [STAT_W-1:0]   status,
	output logic                     table_sel,
	output logic      [IDX_W-1:0]    slot,
	output logic      [PAGE_W-1:0]   page_number,
	output logic      [WORD_W-1:0]   entry_word
);

	logic [CAUSE_W-1:0] opcode_q;
	logic [ADDR_W-1:0]  addr_q;

	logic [1:0][ENTRIES-1:0] valid_q;
	logic [1:0][ENTRIES-1:0] lock_q;
	logic [1:0][IDX_W-1:0]   ptr_q;

	logic                is_miss;
	logic                tsel;
	logic [ENTRIES-1:0]  vsel;
	logic [ENTRIES-1:0]  lsel;
	logic [IDX_W-1:0]    psel;
	logic                found_inv;
	logic [IDX_W-1:0]    inv_idx;
	logic                found_rr;
	logic [IDX_W-1:0]    rr_idx;
	logic [CNT_W-1:0]    rr_sum;
	logic [IDX_W-1:0]    victim;
	logic [IDX_W-1:0]    ptr_nxt;
	logic [ADDR_W-1:0]   page_full;
	logic [ADDR_W-1:0]   page_base;
	logic [WORD_W-1:0]   word_nxt;

	logic [STAT_W-1:0]   status_q;
	logic                table_sel_q;
	logic [IDX_W-1:0]    slot_q;
	logic [PAGE_W-1:0]   page_q;
	logic [WORD_W-1:0]   word_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q <= opcode;
			addr_q   <= fault_addr;
		end
	end

	assign is_miss = (opcode_q == CAUSE_DMISS) || (opcode_q == CAUSE_IMISS);
	assign tsel    = (opcode_q == CAUSE_IMISS) ? TBL_INSTR : TBL_DATA;
	assign vsel    = valid_q[tsel];
	assign lsel    = lock_q[tsel];
	assign psel    = ptr_q[tsel];

	// priority search: first invalid slot, else first unlocked at or after the pointer
	always_comb begin
		found_inv = 1'b0;
		inv_idx   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!found_inv && !vsel[i]) begin
				found_inv = 1'b1;
				inv_idx   = IDX_W'(i);
			end
		end
		found_rr = 1'b0;
		rr_idx   = '0;
		rr_sum   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			rr_sum = {1'b0, psel} + CNT_W'(i);
			if (rr_sum >= CNT_W'(ENTRIES)) rr_sum = rr_sum - CNT_W'(ENTRIES);
			if (!found_rr && !lsel[rr_sum[IDX_W-1:0]]) begin
				found_rr = 1'b1;
				rr_idx   = rr_sum[IDX_W-1:0];
			end
		end
	end

	assign victim  = found_inv ? inv_idx : rr_idx;
	assign ptr_nxt = (rr_idx == IDX_W'(ENTRIES - 1)) ? '0 : rr_idx + IDX_W'(1);

	assign page_full = addr_q >> PAGE_SHIFT;
	assign page_base = page_full << PAGE_SHIFT;

	always_comb begin
		word_nxt = (tsel == TBL_INSTR) ? INSTR_WORD : DATA_WORD;
		if (page_base < ASYNC_BASE) word_nxt = word_nxt | CACHE_BIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// instruction table in the upper row, slot 0 of each holds the L1 entry
			valid_q <= {ENTRIES'(INSTR_RST_WORD[VALID_POS]), ENTRIES'(DATA_RST_WORD[VALID_POS])};
			lock_q  <= {ENTRIES'(INSTR_RST_WORD[LOCK_POS]), ENTRIES'(DATA_RST_WORD[LOCK_POS])};
			ptr_q   <= '0;
		end else if (cmd.exec && is_miss && (found_inv || found_rr)) begin
			valid_q[tsel][victim] <= word_nxt[VALID_POS];
			lock_q[tsel][victim]  <= word_nxt[LOCK_POS];
			// advance the pointer only on a replacement
			if (!found_inv) ptr_q[tsel] <= ptr_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (!is_miss) begin
				status_q    <= ST_UNHANDLED;
				table_sel_q <= 1'b0;
				slot_q      <= '0;
				page_q      <= '0;
				word_q      <= '0;
			end else if (!found_inv && !found_rr) begin
				status_q    <= ST_NO_VICTIM;
				table_sel_q <= tsel;
				slot_q      <= '0;
				page_q      <= page_full[PAGE_W-1:0];
				word_q      <= '0;
			end else begin
				status_q    <= ST_INSTALLED;
				table_sel_q <= tsel;
				slot_q      <= victim;
				page_q      <= page_full[PAGE_W-1:0];
				word_q      <= word_nxt;
			end
		end
	end

	assign status      = status_q;
	assign table_sel   = table_sel_q;
	assign slot        = slot_q;
	assign page_number = page_q;
	assign entry_word  = word_q;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the protection table miss refill core.
module tb;
	import ptmr_pkg::*;

	typedef struct {
		logic [CAUSE_W-1:0] cause;
		logic [ADDR_W-1:0]  addr;
		bit                 drain;
	} miss_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              tbl;
		logic [IDX_W-1:0]  slot;
		logic [PAGE_W-1:0] page;
		logic [WORD_W-1:0] word;
	} refill_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [CAUSE_W-1:0] opcode = '0;
	logic [ADDR_W-1:0] fault_addr = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [STAT_W-1:0] status;
	logic table_sel;
	logic [IDX_W-1:0] slot;
	logic [PAGE_W-1:0] page_number;
	logic [WORD_W-1:0] entry_word;

	// Predictor state: attribute words per table and the round-robin pointers
	logic [WORD_W-1:0] tbl_words [2][ENTRIES];
	logic [IDX_W-1:0] victim_ptr [2];

	miss_req_t pending_reqs[$];
	refill_result_t expected_refills[$];
	miss_req_t drv_req;
	refill_result_t got_refill;
	refill_result_t want_refill;

	bit in_taken = 1'b0;
	int cycle_cnt = 0;
	int mismatch_cnt = 0;
	int accepted_cnt = 0;
	int data_installs = 0;
	int instr_installs = 0;
	int replace_cnt = 0;
	int unhandled_cnt = 0;
	int no_victim_cnt = 0;

	protection_table_miss_refill_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.fault_addr(fault_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.table_sel(table_sel),
		.slot(slot),
		.page_number(page_number),
		.entry_word(entry_word)
	);

	initial forever #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0d] mismatch: %s", cycle_cnt, msg);
		mismatch_cnt++;
	endtask

	task automatic clear_tables();
		for (int t = 0; t < 2; t++) begin
			for (int i = 0; i < ENTRIES; i++)
				tbl_words[t][i] = '0;
			victim_ptr[t] = '0;
		end
		tbl_words[0][0] = DATA_RST_WORD;
		tbl_words[1][0] = INSTR_RST_WORD;
	endtask

	function automatic refill_result_t predict_refill(input logic [CAUSE_W-1:0] cause,
			input logic [ADDR_W-1:0] addr);
		refill_result_t r;
		int t;
		int k;
		int idx;
		bit found;
		logic [WORD_W-1:0] w;
		logic [ADDR_W-1:0] base;
		r = '0;
		if (cause != CAUSE_DMISS && cause != CAUSE_IMISS) begin
			r.status = ST_UNHANDLED;
			unhandled_cnt++;
			return r;
		end
		t = (cause == CAUSE_IMISS) ? 1 : 0;
		r.tbl = (cause == CAUSE_IMISS) ? TBL_INSTR : TBL_DATA;
		r.page = PAGE_W'(addr >> PAGE_SHIFT);
		found = 1'b0;
		k = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!found && !tbl_words[t][i][VALID_POS]) begin
				found = 1'b1;
				k = i;
			end
		end
		// Table full: first unlocked slot at or after the pointer
		if (!found) begin
			for (int i = 0; i < ENTRIES; i++) begin
				idx = (int'(victim_ptr[t]) + i) % ENTRIES;
				if (!found && !tbl_words[t][idx][LOCK_POS]) begin
					found = 1'b1;
					k = idx;
					victim_ptr[t] = IDX_W'((idx + 1) % ENTRIES);
					replace_cnt++;
				end
			end
		end
		if (!found) begin
			r.status = ST_NO_VICTIM;
			no_victim_cnt++;
			return r;
		end
		w = (t == 1) ? INSTR_WORD : DATA_WORD;
		base = (addr >> PAGE_SHIFT) << PAGE_SHIFT;
		if (base < ASYNC_BASE)
			w |= CACHE_BIT;
		tbl_words[t][k] = w;
		r.status = ST_INSTALLED;
		r.slot = IDX_W'(k);
		r.word = w;
		if (t == 1)
			instr_installs++;
		else
			data_installs++;
		return r;
	endfunction

	function automatic bit take_break();
		if (cycle_cnt >= 400 && cycle_cnt < 800)
			return 1'b0;
		return $urandom_range(0, 99) < 9;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_fault_addr();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(32'h1FFF_E000, 32'h2000_1FFF);
			2: return $urandom_range(0, 32'h1FFF_FFFF);
			3: return $urandom() | 32'hFFF0_0000;
			default: return $urandom_range(0, 32'h0000_FFFF);
		endcase
	endfunction

	task automatic queue_req(input logic [CAUSE_W-1:0] cause, input logic [ADDR_W-1:0] addr,
			input bit drain);
		miss_req_t q;
		q.cause = cause;
		q.addr = addr;
		q.drain = drain;
		pending_reqs.push_back(q);
	endtask

	// Driver: hold a stalled transaction, otherwise present the next one or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
		end else if (pending_reqs.size() == 0 || take_break() ||
				(pending_reqs[0].drain && expected_refills.size() != 0)) begin
			in_valid <= 1'b0;
		end else begin
			drv_req = pending_reqs.pop_front();
			in_valid <= 1'b1;
			opcode <= drv_req.cause;
			fault_addr <= drv_req.addr;
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && take_break();
	end

	// Monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		cycle_cnt++;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			expected_refills.push_back(predict_refill(opcode, fault_addr));
			accepted_cnt++;
		end
		if (arst_n && out_valid && !out_stall) begin
			got_refill.status = status;
			got_refill.tbl = table_sel;
			got_refill.slot = slot;
			got_refill.page = page_number;
			got_refill.word = entry_word;
			if (expected_refills.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d slot %0d",
					status, slot));
			end else begin
				want_refill = expected_refills.pop_front();
				if (got_refill.status !== want_refill.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got_refill.status, want_refill.status));
				if (got_refill.tbl !== want_refill.tbl)
					report_mismatch($sformatf("table_sel %0d, expected %0d",
						got_refill.tbl, want_refill.tbl));
				if (got_refill.slot !== want_refill.slot)
					report_mismatch($sformatf("slot %0d, expected %0d",
						got_refill.slot, want_refill.slot));
				if (got_refill.page !== want_refill.page)
					report_mismatch($sformatf("page_number %h, expected %h",
						got_refill.page, want_refill.page));
				if (got_refill.word !== want_refill.word)
					report_mismatch($sformatf("entry_word %h, expected %h",
						got_refill.word, want_refill.word));
			end
		end
	end

	initial begin
		#(12 * 200000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int drain_wait;
		logic [CAUSE_W-1:0] cause;
		clear_tables();

		// Directed: cause extremes and near misses, page boundaries, cacheable edge
		queue_req(6'h00, 32'h0000_0000, 1'b0);
		queue_req(6'h3f, 32'hFFFF_FFFF, 1'b0);
		queue_req(6'h25, 32'h1234_5678, 1'b0);
		queue_req(6'h27, 32'h8765_4321, 1'b0);
		queue_req(6'h2b, 32'h0000_1000, 1'b0);
		queue_req(6'h2d, 32'hFFFF_F000, 1'b0);
		queue_req(6'h06, 32'hAAAA_AAAA, 1'b0);
		queue_req(6'h0c, 32'h5555_5555, 1'b0);
		queue_req(CAUSE_DMISS, 32'h0000_0000, 1'b0);
		queue_req(CAUSE_DMISS, 32'hFFFF_FFFF, 1'b0);
		queue_req(CAUSE_DMISS, 32'h1FFF_FFFF, 1'b0);
		queue_req(CAUSE_DMISS, 32'h2000_0000, 1'b0);
		queue_req(CAUSE_DMISS, 32'h1FFF_F000, 1'b0);
		queue_req(CAUSE_DMISS, 32'h2000_0FFF, 1'b0);
		queue_req(CAUSE_DMISS, DATA_L1_ADDR, 1'b0);
		queue_req(CAUSE_IMISS, 32'h0000_0000, 1'b1);
		queue_req(CAUSE_IMISS, 32'hFFFF_FFFF, 1'b0);
		queue_req(CAUSE_IMISS, 32'h1FFF_FFFF, 1'b0);
		queue_req(CAUSE_IMISS, 32'h2000_0000, 1'b0);
		queue_req(CAUSE_IMISS, 32'h1FFF_F000, 1'b0);
		queue_req(CAUSE_IMISS, 32'h2000_0FFF, 1'b0);
		queue_req(CAUSE_IMISS, INSTR_L1_ADDR, 1'b0);

		// Random: mostly misses so both tables fill and the pointers wrap
		for (int i = 0; i < 650; i++) begin
			case ($urandom_range(0, 9))
				0, 1: cause = CAUSE_W'($urandom_range(0, 63));
				2, 3, 4, 5: cause = CAUSE_DMISS;
				default: cause = CAUSE_IMISS;
			endcase
			queue_req(cause, pick_fault_addr(), (i % 150) == 75);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		drain_wait = 0;
		while (expected_refills.size() != 0 && drain_wait < 2000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (expected_refills.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_refills.size()));

		$display("Ran %0d transactions: %0d data and %0d instruction installs, %0d replacements",
			accepted_cnt, data_installs, instr_installs, replace_cnt);
		$display("  %0d unhandled causes, %0d no-victim, %0d mismatches",
			unhandled_cnt, no_victim_cnt, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
